// ===== design/ppie_pkg.sv =====
// shared types, constants and helpers for the parallelepiped query pipeline
package ppie_pkg;

    localparam int COORD_W = 32;
    localparam int COMP_W  = 21;
    localparam int PROD_W  = COMP_W + COORD_W;       // one normal component times a coordinate
    localparam int DOT_W   = PROD_W + 2;             // sum of three products
    localparam int NUM_W   = DOT_W + 1;              // dot plus scaled offset
    localparam int A_W     = NUM_W - 1;              // nonnegative numerator magnitude
    localparam int B_W     = DOT_W - 1;              // positive denominator magnitude
    localparam int OFF_SHIFT = 19;                   // Q16.16 offset to Q.35
    localparam int FRAC_W  = 16;
    localparam int TQ_W    = 30;                     // Q14.16 ray distance below the limit
    localparam int LIM_W   = B_W + 14;
    localparam int T_LIMIT = 10000;
    localparam int NPLANES = 6;
    localparam int NNORM   = 3;
    localparam int IDX_W   = 3;
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;
    localparam int NORM_W  = 63;

    // register indexes
    localparam logic [2:0] REG_SHAPE_VALID   = 3'd0;
    localparam logic [2:0] REG_NORMAL_ONE    = 3'd1;
    localparam logic [2:0] REG_NORMAL_TWO    = 3'd2;
    localparam logic [2:0] REG_NORMAL_THREE  = 3'd3;
    localparam logic [2:0] REG_OFFSETS_ONE   = 3'd4;
    localparam logic [2:0] REG_OFFSETS_TWO   = 3'd5;
    localparam logic [2:0] REG_OFFSETS_THREE = 3'd6;

    localparam logic MODE_INSIDE = 1'b0;
    localparam logic MODE_RAY    = 1'b1;

    typedef struct packed {
        logic                       mode;
        logic signed [COORD_W-1:0]  point_x;
        logic signed [COORD_W-1:0]  point_y;
        logic signed [COORD_W-1:0]  point_z;
        logic signed [COORD_W-1:0]  dir_x;
        logic signed [COORD_W-1:0]  dir_y;
        logic signed [COORD_W-1:0]  dir_z;
    } in_item_t;

    typedef struct packed {
        logic                       inside_res;
        logic                       hit;
        logic [IDX_W-1:0]           hit_plane;
        logic [TQ_W-1:0]            ray_distance;
        logic signed [COORD_W-1:0]  entry_x;
        logic signed [COORD_W-1:0]  entry_y;
        logic signed [COORD_W-1:0]  entry_z;
    } out_item_t;

    // one plane candidate: t = num / den
    typedef struct packed {
        logic             ok;
        logic [A_W-1:0]   num;
        logic [B_W-1:0]   den;
        logic [IDX_W-1:0] idx;
    } cand_t;

    // request fields that ride along with the arithmetic
    typedef struct packed {
        logic                       mode;
        logic                       in_box;
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
        logic signed [COORD_W-1:0]  pz;
        logic signed [COORD_W-1:0]  vx;
        logic signed [COORD_W-1:0]  vy;
        logic signed [COORD_W-1:0]  vz;
    } carry_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
        carry_t           carry;
    } div_tag_t;

    function automatic logic signed [COMP_W-1:0] comp_of(logic [NORM_W-1:0] n, int c);
        return n[COMP_W*c +: COMP_W];
    endfunction

endpackage

// ===== design/parallelepiped_inside_and_ray_entry.sv =====
// top level: configuration registers and the parallelepiped query pipeline
//
// Each request is a point, a ray direction and a mode. Mode 0 tells whether the point lies
// between all three pairs of planes; mode 1 finds the nearest plane that the ray meets with
// 0 <= t < 10000 and returns t (Q14.16), the plane index and the saturated entry point.
// The pipeline takes one request every cycle unless a result stalls, and its stages are:
// two stages of dot products, sign fixup and range check, three rounds of exact two-stage
// ratio compares, a 30-stage bit-per-stage divider and two stages for the entry point.
// A stalled result holds the whole pipeline, so s_ready follows m_ready while m_valid is high.
// Registers sit at byte address 8*i on a 64-bit APB-style port; the user must write them only while
// no request is in flight, and the block itself does not enforce this. A write to address index 7 is ignored.
module parallelepiped_inside_and_ray_entry (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ppie_pkg::in_item_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ppie_pkg::out_item_t            m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ppie_pkg::ADDR_W-1:0]    paddr,
    input  logic [ppie_pkg::DATA_W-1:0]    pwdata,
    output logic [ppie_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    localparam int NN = ppie_pkg::NNORM;
    localparam int NP = ppie_pkg::NPLANES;

    // ---------------- configuration registers ----------------
    logic                         shape_valid_reg;
    logic [ppie_pkg::NORM_W-1:0]  normal_reg  [NN];
    logic [ppie_pkg::DATA_W-1:0]  offsets_reg [NN];
    logic [2:0]                   reg_index;
    logic                         cfg_wr;

    assign pready    = 1'b1;
    assign reg_index = paddr[5:3];
    assign cfg_wr    = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_valid_reg <= 1'b0;
            for (int k = 0; k < NN; k++) begin
                normal_reg[k]  <= '0;
                offsets_reg[k] <= '0;
            end
        end else if (cfg_wr) begin
            case (reg_index)
                ppie_pkg::REG_SHAPE_VALID:   shape_valid_reg <= pwdata[0];
                ppie_pkg::REG_NORMAL_ONE:    normal_reg[0]   <= pwdata[ppie_pkg::NORM_W-1:0];
                ppie_pkg::REG_NORMAL_TWO:    normal_reg[1]   <= pwdata[ppie_pkg::NORM_W-1:0];
                ppie_pkg::REG_NORMAL_THREE:  normal_reg[2]   <= pwdata[ppie_pkg::NORM_W-1:0];
                ppie_pkg::REG_OFFSETS_ONE:   offsets_reg[0]  <= pwdata;
                ppie_pkg::REG_OFFSETS_TWO:   offsets_reg[1]  <= pwdata;
                ppie_pkg::REG_OFFSETS_THREE: offsets_reg[2]  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            ppie_pkg::REG_SHAPE_VALID:   prdata = ppie_pkg::DATA_W'(shape_valid_reg);
            ppie_pkg::REG_NORMAL_ONE:    prdata = ppie_pkg::DATA_W'(normal_reg[0]);
            ppie_pkg::REG_NORMAL_TWO:    prdata = ppie_pkg::DATA_W'(normal_reg[1]);
            ppie_pkg::REG_NORMAL_THREE:  prdata = ppie_pkg::DATA_W'(normal_reg[2]);
            ppie_pkg::REG_OFFSETS_ONE:   prdata = offsets_reg[0];
            ppie_pkg::REG_OFFSETS_TWO:   prdata = offsets_reg[1];
            ppie_pkg::REG_OFFSETS_THREE: prdata = offsets_reg[2];
            default:                     prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // one enable for every stage: move on unless a result is waiting to be taken
    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage 1: normal component products
    logic                          vld1_reg;
    ppie_pkg::carry_t              carry1_reg;
    logic signed [ppie_pkg::PROD_W-1:0] pp_reg [NN][3];
    logic signed [ppie_pkg::PROD_W-1:0] pv_reg [NN][3];
    logic signed [ppie_pkg::COORD_W-1:0] pin [3];
    logic signed [ppie_pkg::COORD_W-1:0] vin [3];
    ppie_pkg::carry_t              carry_in;

    always_comb begin
        pin[0] = s_data.point_x;
        pin[1] = s_data.point_y;
        pin[2] = s_data.point_z;
        vin[0] = s_data.dir_x;
        vin[1] = s_data.dir_y;
        vin[2] = s_data.dir_z;
        carry_in.mode   = s_data.mode;
        carry_in.in_box = 1'b0;
        carry_in.px     = s_data.point_x;
        carry_in.py     = s_data.point_y;
        carry_in.pz     = s_data.point_z;
        carry_in.vx     = s_data.dir_x;
        carry_in.vy     = s_data.dir_y;
        carry_in.vz     = s_data.dir_z;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            carry1_reg <= carry_in;
            for (int k = 0; k < NN; k++) begin
                for (int c = 0; c < 3; c++) begin
                    pp_reg[k][c] <= ppie_pkg::PROD_W'(ppie_pkg::comp_of(normal_reg[k], c))
                                  * ppie_pkg::PROD_W'(pin[c]);
                    pv_reg[k][c] <= ppie_pkg::PROD_W'(ppie_pkg::comp_of(normal_reg[k], c))
                                  * ppie_pkg::PROD_W'(vin[c]);
                end
            end
        end
    end

    // stage 2: plane distances (numerators) and denominators
    logic                          vld2_reg;
    ppie_pkg::carry_t              carry2_reg;
    logic signed [ppie_pkg::NUM_W-1:0] num2_reg [NP];
    logic signed [ppie_pkg::DOT_W-1:0] den2_reg [NN];

    always_ff @(posedge aclk) begin
        if (en) begin
            carry2_reg <= carry1_reg;
            for (int i = 0; i < NP; i++) begin
                // primary offset in the low half, secondary in the high half
                num2_reg[i] <= ppie_pkg::NUM_W'(pp_reg[i % NN][0])
                             + ppie_pkg::NUM_W'(pp_reg[i % NN][1])
                             + ppie_pkg::NUM_W'(pp_reg[i % NN][2])
                             + (ppie_pkg::NUM_W'($signed(offsets_reg[i % NN][(i / NN) * 32 +: 32]))
                                <<< ppie_pkg::OFF_SHIFT);
            end
            for (int k = 0; k < NN; k++) begin
                den2_reg[k] <= ppie_pkg::DOT_W'(pv_reg[k][0]) + ppie_pkg::DOT_W'(pv_reg[k][1])
                             + ppie_pkg::DOT_W'(pv_reg[k][2]);
            end
        end
    end

    // stage 3: fold signs so that t = num / den with den positive
    logic                   vld3_reg;
    ppie_pkg::carry_t       carry3_reg;
    ppie_pkg::cand_t        cand3_reg [NP];
    logic                   in_box2;

    always_comb begin
        in_box2 = 1'b1;
        for (int i = 0; i < NN; i++) begin
            if (num2_reg[i] < 0) in_box2 = 1'b0;
            if (num2_reg[i + NN] > 0) in_box2 = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [ppie_pkg::NUM_W-1:0] a_s;
        logic signed [ppie_pkg::DOT_W-1:0] b_s;
        logic signed [ppie_pkg::DOT_W-1:0] d;
        ppie_pkg::carry_t                  c3;
        if (en) begin
            c3        = carry2_reg;
            c3.in_box = in_box2;
            carry3_reg <= c3;
            for (int i = 0; i < NP; i++) begin
                d   = den2_reg[i % NN];
                a_s = d[ppie_pkg::DOT_W-1] ? num2_reg[i] : -num2_reg[i];
                b_s = d[ppie_pkg::DOT_W-1] ? -d : d;
                cand3_reg[i].ok  <= (d != 0) && !a_s[ppie_pkg::NUM_W-1];
                cand3_reg[i].num <= a_s[ppie_pkg::A_W-1:0];
                cand3_reg[i].den <= b_s[ppie_pkg::B_W-1:0];
                cand3_reg[i].idx <= ppie_pkg::IDX_W'(i);
            end
        end
    end

    // stage 4: t below the limit, that is num < 10000 * den
    logic                   vld4_reg;
    ppie_pkg::carry_t       carry4_reg;
    ppie_pkg::cand_t        cand4_reg [NP];

    always_ff @(posedge aclk) begin
        ppie_pkg::cand_t c4;
        if (en) begin
            carry4_reg <= carry3_reg;
            for (int i = 0; i < NP; i++) begin
                c4    = cand3_reg[i];
                c4.ok = cand3_reg[i].ok
                    && (ppie_pkg::LIM_W'(cand3_reg[i].num)
                        < ppie_pkg::LIM_W'(cand3_reg[i].den) * ppie_pkg::LIM_W'(ppie_pkg::T_LIMIT));
                cand4_reg[i] <= c4;
            end
        end
    end

    // selection tree: pairs, then quads, then the last pair
    ppie_pkg::cand_t w01, w23, w45, w0123, wbest;
    ppie_pkg::cand_t w45d1_reg, w45d2_reg;

    ppie_sel u_sel01 (.aclk(aclk), .en(en), .lo(cand4_reg[0]), .hi(cand4_reg[1]), .win(w01));
    ppie_sel u_sel23 (.aclk(aclk), .en(en), .lo(cand4_reg[2]), .hi(cand4_reg[3]), .win(w23));
    ppie_sel u_sel45 (.aclk(aclk), .en(en), .lo(cand4_reg[4]), .hi(cand4_reg[5]), .win(w45));
    ppie_sel u_sel03 (.aclk(aclk), .en(en), .lo(w01), .hi(w23), .win(w0123));
    ppie_sel u_sel05 (.aclk(aclk), .en(en), .lo(w0123), .hi(w45d2_reg), .win(wbest));

    // request fields and valid bits ride along the six compare stages
    localparam int SEL_D = 6;
    logic             vsel_reg [SEL_D];
    ppie_pkg::carry_t csel_reg [SEL_D];

    always_ff @(posedge aclk) begin
        if (en) begin
            w45d1_reg <= w45;
            w45d2_reg <= w45d1_reg;
            csel_reg[0] <= carry4_reg;
            for (int s = 1; s < SEL_D; s++) csel_reg[s] <= csel_reg[s-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            for (int s = 0; s < SEL_D; s++) vsel_reg[s] <= 1'b0;
        end else if (en) begin
            vld1_reg <= s_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vsel_reg[0] <= vld4_reg;
            for (int s = 1; s < SEL_D; s++) vsel_reg[s] <= vsel_reg[s-1];
        end
    end

    // divider: t in Q14.16
    ppie_pkg::div_tag_t tag_in, tag_out;
    logic               div_vld;
    logic [ppie_pkg::TQ_W-1:0] tq;

    always_comb begin
        tag_in.hit   = wbest.ok;
        tag_in.idx   = wbest.idx;
        tag_in.carry = csel_reg[SEL_D-1];
    end

    ppie_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (vsel_reg[SEL_D-1]),
        .a_in    (wbest.num),
        .b_in    (wbest.den),
        .tag_in  (tag_in),
        .out_vld (div_vld),
        .tq      (tq),
        .tag_out (tag_out)
    );

    // entry stage 1: t times direction
    localparam int EP_W = ppie_pkg::TQ_W + 1 + ppie_pkg::COORD_W;
    logic                       vlde_reg;
    ppie_pkg::div_tag_t         tage_reg;
    logic [ppie_pkg::TQ_W-1:0]  tqe_reg;
    logic signed [EP_W-1:0]     ep_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            tage_reg <= tag_out;
            tqe_reg  <= tq;
            ep_reg[0] <= EP_W'($signed({1'b0, tq})) * EP_W'(tag_out.carry.vx);
            ep_reg[1] <= EP_W'($signed({1'b0, tq})) * EP_W'(tag_out.carry.vy);
            ep_reg[2] <= EP_W'($signed({1'b0, tq})) * EP_W'(tag_out.carry.vz);
        end
    end

    // entry stage 2: origin plus floored step, saturated; result register
    localparam int ES_W = EP_W - ppie_pkg::FRAC_W + 1;
    ppie_pkg::out_item_t out_reg, out_next;
    logic signed [ppie_pkg::COORD_W-1:0] pe [3];
    logic signed [ppie_pkg::COORD_W-1:0] ent [3];
    logic signed [ES_W-1:0] esum;
    logic                   shows_hit;

    always_comb begin
        pe[0] = tage_reg.carry.px;
        pe[1] = tage_reg.carry.py;
        pe[2] = tage_reg.carry.pz;
        for (int c = 0; c < 3; c++) begin
            esum = ES_W'(pe[c]) + ES_W'(ep_reg[c] >>> ppie_pkg::FRAC_W);
            if (esum > ES_W'(32'sh7FFF_FFFF))
                ent[c] = 32'sh7FFF_FFFF;
            else if (esum < ES_W'(32'sh8000_0000))
                ent[c] = 32'sh8000_0000;
            else
                ent[c] = esum[ppie_pkg::COORD_W-1:0];
        end
        shows_hit = shape_valid_reg && (tage_reg.carry.mode == ppie_pkg::MODE_RAY)
                  && tage_reg.hit;
        out_next.inside_res   = shape_valid_reg && (tage_reg.carry.mode == ppie_pkg::MODE_INSIDE)
                              && tage_reg.carry.in_box;
        out_next.hit          = shows_hit;
        out_next.hit_plane    = shows_hit ? tage_reg.idx : '0;
        out_next.ray_distance = shows_hit ? tqe_reg : '0;
        out_next.entry_x      = shows_hit ? ent[0] : '0;
        out_next.entry_y      = shows_hit ? ent[1] : '0;
        out_next.entry_z      = shows_hit ? ent[2] : '0;
    end

    always_ff @(posedge aclk) begin
        if (en) out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vlde_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vlde_reg    <= div_vld;
            m_valid_reg <= vlde_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
endmodule

// ===== design/ppie_sel.sv =====
// two-stage exact ratio compare, keeps the lower plane on ties
module ppie_sel (
    input  logic            aclk,
    input  logic            en,
    input  ppie_pkg::cand_t lo,
    input  ppie_pkg::cand_t hi,
    output ppie_pkg::cand_t win
);
    localparam int AL_W = 28;
    localparam int AH_W = ppie_pkg::A_W - AL_W;
    localparam int BL_W = 27;
    localparam int BH_W = ppie_pkg::B_W - BL_W;
    localparam int FULL_W = ppie_pkg::A_W + ppie_pkg::B_W;

    typedef struct packed {
        logic [AL_W+BL_W-1:0] ll;
        logic [AL_W+BH_W-1:0] lh;
        logic [AH_W+BL_W-1:0] hl;
        logic [AH_W+BH_W-1:0] hh;
    } parts_t;

    parts_t          phi_reg, plo_reg;
    ppie_pkg::cand_t lo_reg, hi_reg, win_reg;

    function automatic parts_t split_mul(logic [ppie_pkg::A_W-1:0] a,
                                        logic [ppie_pkg::B_W-1:0] b);
        parts_t p;
        p.ll = a[AL_W-1:0] * b[BL_W-1:0];
        p.lh = a[AL_W-1:0] * b[ppie_pkg::B_W-1:BL_W];
        p.hl = a[ppie_pkg::A_W-1:AL_W] * b[BL_W-1:0];
        p.hh = a[ppie_pkg::A_W-1:AL_W] * b[ppie_pkg::B_W-1:BL_W];
        return p;
    endfunction

    function automatic logic [FULL_W-1:0] join_parts(parts_t p);
        return FULL_W'(p.ll) + (FULL_W'(p.lh) << BL_W) + (FULL_W'(p.hl) << AL_W)
             + (FULL_W'(p.hh) << (AL_W + BL_W));
    endfunction

    logic [FULL_W-1:0] cross_hi, cross_lo;
    logic              pick_hi;

    always_comb begin
        cross_hi = join_parts(phi_reg);
        cross_lo = join_parts(plo_reg);
        pick_hi  = hi_reg.ok && (!lo_reg.ok || (cross_hi < cross_lo));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            phi_reg <= split_mul(hi.num, lo.den);
            plo_reg <= split_mul(lo.num, hi.den);
            lo_reg  <= lo;
            hi_reg  <= hi;
            win_reg <= pick_hi ? hi_reg : lo_reg;
        end
    end

    assign win = win_reg;
endmodule

// ===== design/ppie_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module ppie_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_vld,
    input  logic [ppie_pkg::A_W-1:0]   a_in,
    input  logic [ppie_pkg::B_W-1:0]   b_in,
    input  ppie_pkg::div_tag_t         tag_in,
    output logic                       out_vld,
    output logic [ppie_pkg::TQ_W-1:0]  tq,
    output ppie_pkg::div_tag_t         tag_out
);
    localparam int N = ppie_pkg::TQ_W;

    logic                      vld_reg [N];
    logic [ppie_pkg::A_W-1:0]  r_reg   [N];
    logic [ppie_pkg::A_W-1:0]  a_reg   [N];
    logic [ppie_pkg::B_W-1:0]  b_reg   [N];
    logic [N-1:0]              q_reg   [N];
    ppie_pkg::div_tag_t        tag_reg [N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        localparam int J = N - 1 - s;
        logic                      vld_src;
        logic [ppie_pkg::A_W-1:0]  r_src, a_src;
        logic [ppie_pkg::B_W-1:0]  b_src;
        logic [N-1:0]              q_src;
        ppie_pkg::div_tag_t        tag_src;
        logic                      inbit, ge;
        logic [ppie_pkg::A_W:0]    rs;

        if (s == 0) begin : g_first
            assign vld_src = in_vld;
            assign r_src   = ppie_pkg::A_W'(a_in >> (N - ppie_pkg::FRAC_W));
            assign a_src   = a_in;
            assign b_src   = b_in;
            assign q_src   = '0;
            assign tag_src = tag_in;
        end else begin : g_next
            assign vld_src = vld_reg[s-1];
            assign r_src   = r_reg[s-1];
            assign a_src   = a_reg[s-1];
            assign b_src   = b_reg[s-1];
            assign q_src   = q_reg[s-1];
            assign tag_src = tag_reg[s-1];
        end

        if (J >= ppie_pkg::FRAC_W) begin : g_bit
            assign inbit = a_src[J - ppie_pkg::FRAC_W];
        end else begin : g_zero
            assign inbit = 1'b0;
        end

        assign rs = {r_src, inbit};
        assign ge = rs >= (ppie_pkg::A_W + 1)'(b_src);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[s]   <= ge ? ppie_pkg::A_W'(rs - (ppie_pkg::A_W + 1)'(b_src))
                                 : ppie_pkg::A_W'(rs);
                q_reg[s]   <= {q_src[N-2:0], ge};
                a_reg[s]   <= a_src;
                b_reg[s]   <= b_src;
                tag_reg[s] <= tag_src;
            end
        end
    end

    assign out_vld = vld_reg[N-1];
    assign tq      = q_reg[N-1];
    assign tag_out = tag_reg[N-1];
endmodule

// ===== dv/ppie_query_checker.sv =====
// checker: tracks register writes, predicts each query answer and compares results
module ppie_query_checker
    import ppie_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output int                    mismatches,
    output int                    outstanding
);

    logic              shape_ok;
    logic [NORM_W-1:0] normals [NNORM];
    logic [63:0]       offsets [NNORM];
    out_item_t         expected_answers [$];

    function automatic longint norm_comp(int k, int c);
        logic signed [COMP_W-1:0] t;
        t = normals[k % 3][COMP_W*c +: COMP_W];
        return longint'(t);
    endfunction

    function automatic out_item_t predict_query(in_item_t q);
        out_item_t   o;
        longint      p [3];
        longint      v [3];
        longint      num, den, a, b, tl, prod, e;
        logic signed [31:0] off;
        logic [63:0] ua, ub, ba, bb;
        logic [127:0] lhs, rhs;
        logic [79:0] tq;
        bit          found;
        int          best;
        o = '0;
        p[0] = q.point_x; p[1] = q.point_y; p[2] = q.point_z;
        v[0] = q.dir_x;   v[1] = q.dir_y;   v[2] = q.dir_z;
        if (!shape_ok) return o;
        found = 0; best = 0; ba = 0; bb = 1;
        if (q.mode == MODE_INSIDE) begin
            o.inside_res = 1'b1;
        end
        for (int i = 0; i < NPLANES; i++) begin
            off = (i < 3) ? offsets[i % 3][31:0] : offsets[i % 3][63:32];
            num = norm_comp(i, 0) * p[0] + norm_comp(i, 1) * p[1] + norm_comp(i, 2) * p[2]
                  + longint'(off) * 64'sd524288;
            if (q.mode == MODE_INSIDE) begin
                if (i < 3 && num < 0) o.inside_res = 1'b0;
                if (i >= 3 && num > 0) o.inside_res = 1'b0;
                continue;
            end
            den = norm_comp(i, 0) * v[0] + norm_comp(i, 1) * v[1] + norm_comp(i, 2) * v[2];
            if (den == 0) continue;
            a = -num; b = den;
            if (b < 0) begin
                a = -a; b = -b;
            end
            if (a < 0) continue;
            ua = a; ub = b;
            // beyond the distance limit
            if (ua / T_LIMIT >= ub) continue;
            lhs = {64'b0, ua} * {64'b0, bb};
            rhs = {64'b0, ba} * {64'b0, ub};
            if (!found || lhs < rhs) begin
                found = 1; best = i; ba = ua; bb = ub;
            end
        end
        if (q.mode == MODE_INSIDE || !found) return o;
        tq = {ba, 16'b0} / {16'b0, bb};
        o.hit = 1'b1;
        o.hit_plane = best[IDX_W-1:0];
        o.ray_distance = tq[TQ_W-1:0];
        tl = tq[TQ_W-1:0];
        for (int c = 0; c < 3; c++) begin
            prod = tl * v[c];
            e = p[c] + (prod >>> 16);
            if (e > 64'sd2147483647) e = 64'sd2147483647;
            if (e < -64'sd2147483648) e = -64'sd2147483648;
            if (c == 0) o.entry_x = e[31:0];
            else if (c == 1) o.entry_y = e[31:0];
            else o.entry_z = e[31:0];
        end
        return o;
    endfunction

    assign outstanding = expected_answers.size();

    always @(posedge aclk) begin
        out_item_t exp_item;
        int        idx;
        if (!aresetn) begin
            shape_ok <= 1'b0;
            for (int k = 0; k < NNORM; k++) begin
                normals[k] <= '0;
                offsets[k] <= '0;
            end
            mismatches <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                idx = paddr >> 3;
                if (idx == REG_SHAPE_VALID) shape_ok <= pwdata[0];
                else if (idx <= REG_NORMAL_THREE) normals[idx - 1] <= pwdata[NORM_W-1:0];
                else if (idx <= REG_OFFSETS_THREE) offsets[idx - 4] <= pwdata;
            end
            if (s_valid && s_ready) expected_answers.push_back(predict_query(s_data));
            if (m_valid && m_ready) begin
                if (expected_answers.size() == 0) begin
                    if (mismatches < 10) $display("result with no request pending: %p", m_data);
                    mismatches <= mismatches + 1;
                end else begin
                    exp_item = expected_answers.pop_front();
                    if (m_data.inside_res !== exp_item.inside_res || m_data.hit !== exp_item.hit
                        || m_data.hit_plane !== exp_item.hit_plane
                        || m_data.ray_distance !== exp_item.ray_distance
                        || m_data.entry_x !== exp_item.entry_x
                        || m_data.entry_y !== exp_item.entry_y
                        || m_data.entry_z !== exp_item.entry_z) begin
                        if (mismatches < 10)
                            $display("mismatch: expected %p actual %p", exp_item, m_data);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// testbench top: clock, reset, register setup, query traffic and verdict
module tb_top;
    import ppie_pkg::*;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    in_item_t           s_data;
    logic               m_valid;
    logic               m_ready;
    out_item_t          m_data;
    logic               psel, penable, pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    int                 mismatches;
    int                 outstanding;
    bit                 calm;       // when set, neither side idles

    parallelepiped_inside_and_ray_entry i_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    ppie_query_checker i_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .mismatches, .outstanding
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    // one Q1.19 normal, components packed x,y,z
    function automatic logic [63:0] pack_normal(logic [20:0] x, logic [20:0] y, logic [20:0] z);
        return {1'b0, z, y, x};
    endfunction

    // register write: setup cycle, access cycle, then idle
    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 3; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // let the pipeline empty before touching registers
    task automatic wait_idle();
        while (outstanding != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // axis-aligned box of half-size h units centered at the origin
    task automatic load_box(int h);
        reg_write(REG_NORMAL_ONE,   pack_normal(21'd524288, 21'd0, 21'd0));
        reg_write(REG_NORMAL_TWO,   pack_normal(21'd0, 21'd524288, 21'd0));
        reg_write(REG_NORMAL_THREE, pack_normal(21'd0, 21'd0, 21'd524288));
        reg_write(REG_OFFSETS_ONE,   {32'(-(h <<< 16)), 32'(h <<< 16)});
        reg_write(REG_OFFSETS_TWO,   {32'(-(h <<< 16)), 32'(h <<< 16)});
        reg_write(REG_OFFSETS_THREE, {32'(-(h <<< 16)), 32'(h <<< 16)});
    endtask

    task automatic send_request(in_item_t item);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // mostly coordinates near the shape, sometimes any 32-bit value
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'd0;
            default: return 32'($urandom_range(0, 40 << 16)) - 32'(20 << 16);
        endcase
    endfunction

    function automatic in_item_t rand_request();
        in_item_t r;
        r.mode    = 1'($urandom_range(0, 1));
        r.point_x = rand_coord(); r.point_y = rand_coord(); r.point_z = rand_coord();
        r.dir_x   = rand_coord(); r.dir_y   = rand_coord(); r.dir_z   = rand_coord();
        return r;
    endfunction

    task automatic send_random(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 40) == 0) calm = ~calm;
            send_request(rand_request());
        end
    endtask

    task automatic send_q(logic mode, int px, int py, int pz, int vx, int vy, int vz);
        in_item_t r;
        r.mode = mode;
        r.point_x = px; r.point_y = py; r.point_z = pz;
        r.dir_x = vx;   r.dir_y = vy;   r.dir_z = vz;
        send_request(r);
    endtask

    task automatic random_shape();
        for (int k = 0; k < 3; k++) begin
            reg_write(REG_NORMAL_ONE + 3'(k), {$urandom, $urandom});
            reg_write(REG_OFFSETS_ONE + 3'(k),
                      {32'($urandom_range(0, 40 << 16)) - 32'(20 << 16),
                       32'($urandom_range(0, 40 << 16)) - 32'(20 << 16)});
        end
    endtask

    // receiver: random stalls per result, with calm stretches
    initial begin
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    localparam int ONE = 1 << 16;

    initial begin
        int wait_cycles;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        calm = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // shape not loaded: every answer is all zero
        send_q(MODE_INSIDE, 0, 0, 0, 0, 0, 0);
        send_q(MODE_RAY, -20 * ONE, 0, 0, ONE, 0, 0);
        send_random(50);
        s_valid <= 1'b0;
        wait_idle();

        // box of half-size 10, directed corners of the behavior
        load_box(10);
        reg_write(REG_SHAPE_VALID, 64'd1);
        send_q(MODE_INSIDE, 0, 0, 0, 0, 0, 0);                     // inside
        send_q(MODE_INSIDE, 10 * ONE, -10 * ONE, 10 * ONE, 0, 0, 0);  // on the faces
        send_q(MODE_INSIDE, 11 * ONE, 0, 0, 0, 0, 0);               // outside
        send_q(MODE_INSIDE, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
               32'h80000000, 32'h7fffffff, 32'h80000000);
        send_q(MODE_RAY, -20 * ONE, 0, 0, ONE, 0, 0);              // plain hit
        send_q(MODE_RAY, -20 * ONE, -20 * ONE, 0, ONE, ONE, 0);     // tie on two planes
        send_q(MODE_RAY, 0, 0, 0, 0, 0, 0);                         // all denominators zero
        send_q(MODE_RAY, 20 * ONE, 0, 0, ONE, 0, 0);                // moving away
        send_q(MODE_RAY, -20 * ONE, 0, 0, 1, 0, 0);                 // t past the limit
        send_q(MODE_RAY, -11 * ONE, 0, 0, 1, 0, 0);                 // t still past the limit
        send_q(MODE_RAY, 32'h80000000, 32'h7fffffff, 32'h80000000,
               32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_q(MODE_RAY, 32'h7fff0000, 5 * ONE, 0, 32'h80000000, 32'h7fffffff, 0); // saturation
        send_q(MODE_RAY, 32'hffffffff, 32'hffffffff, 32'hffffffff,
               32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_random(150);
        // hold off until every answer is back
        s_valid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        send_random(150);
        s_valid <= 1'b0;
        wait_idle();

        // random slanted planes
        random_shape();
        calm = 1;
        send_random(300);
        s_valid <= 1'b0;
        wait_idle();

        // most negative components and extreme offsets
        for (int k = 0; k < 3; k++) begin
            reg_write(REG_NORMAL_ONE + 3'(k), pack_normal(21'h100000, 21'h100000, 21'h100000));
            reg_write(REG_OFFSETS_ONE + 3'(k), {32'h80000000, 32'h7fffffff});
        end
        send_random(150);
        s_valid <= 1'b0;
        wait_idle();

        // most positive components, offsets swapped
        for (int k = 0; k < 3; k++) begin
            reg_write(REG_NORMAL_ONE + 3'(k), pack_normal(21'h0fffff, 21'h0fffff, 21'h0fffff));
            reg_write(REG_OFFSETS_ONE + 3'(k), {32'h7fffffff, 32'h80000000});
        end
        send_random(150);
        s_valid <= 1'b0;
        wait_idle();

        // another random shape, then the unmapped index
        random_shape();
        reg_write(3'd7, {$urandom, $urandom});
        send_random(250);
        s_valid <= 1'b0;
        wait_idle();

        // planes loaded but shape cleared
        load_box(5);
        reg_write(REG_SHAPE_VALID, 64'd0);
        send_random(100);
        s_valid <= 1'b0;

        wait_cycles = 0;
        while (outstanding != 0 && wait_cycles < 100000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (60) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
